// ===== src/dual_stack_shared_memory_unit_assert.svh =====
// Assertion macros shared by the checker files of the dual stack unit.
`ifndef DUAL_STACK_SHARED_MEMORY_UNIT_ASSERT_SVH
`define DUAL_STACK_SHARED_MEMORY_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DSSM_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DSSM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/dssm_pkg.sv =====
// Package with the types and constants of the dual stack shared memory unit.
package dssm_pkg;

    localparam int unsigned DEPTH_DEF = 128;
    localparam int unsigned WORD_W    = 32;

    localparam logic signed [WORD_W-1:0] POP_FAIL_VALUE = '1;
    localparam logic signed [WORD_W-1:0] PUSH_RESULT_VALUE = '0;

    typedef enum logic [1:0] {
        MODE_PUSH_A = 2'd0,
        MODE_PUSH_B = 2'd1,
        MODE_POP_A  = 2'd2,
        MODE_POP_B  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } status_t;

    typedef struct packed {
        logic exec;
        logic load_imm;
        logic load_mem;
    } dssm_cmd_t;

    typedef struct packed {
        logic a_empty;
        logic b_empty;
    } dssm_stat_t;

endpackage

// ===== src/dssm_if.sv =====
// Valid/ready channel interfaces for the request and result transactions.
interface dssm_in_if
    import dssm_pkg::*;
();
    logic                     valid;
    logic                     ready;
    mode_t                    mode;
    logic signed [WORD_W-1:0] push_value;

    modport source (output valid, output mode, output push_value, input ready);
    modport sink (input valid, input mode, input push_value, output ready);
endinterface

interface dssm_out_if
    import dssm_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [WORD_W-1:0] pop_value;
    status_t                  status;

    modport source (output valid, output pop_value, output status, input ready);
    modport sink (input valid, input pop_value, input status, output ready);
endinterface

// ===== src/dual_stack_shared_memory_unit.sv =====
// Top level of the dual stack shared memory unit.
//
// Requests arrive on in_ch as transactions carrying mode and push_value; each one
// yields exactly one result transaction on out_ch with pop_value and status.
// Stack A grows up from word 0 and stack B grows down from word DEPTH-1 of a
// single-port RAM.
// A push, or a pop of an empty stack, loads the result register directly: the
// result is visible the cycle after the request is accepted, and the next
// request may follow at once. A pop that reads the RAM goes through the
// registered RAM read and then the result register load, during which no new
// request is taken; pushes are taken at one per cycle while the receiver keeps up.
// A new request is taken while a finished result is still waiting, as long as
// the result register is taken in the same cycle or is empty.
// When the receiver stalls, the result holds and the next request waits.
// Reset clears both stack counts and the result valid; the RAM contents are
// not cleared and need no clearing pass, since a pop reads only pushed words.
module dual_stack_shared_memory_unit
    import dssm_pkg::*;
#(
    parameter int unsigned DEPTH = DEPTH_DEF
) (
    input logic     clk,
    input logic     rst_n,
    dssm_in_if.sink in_ch,
    dssm_out_if.source out_ch
);
    dssm_cmd_t  cmd;
    dssm_stat_t stat;

    dssm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .mode      (in_ch.mode),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    dssm_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .mode       (in_ch.mode),
        .push_value (in_ch.push_value),
        .cmd        (cmd),
        .stat       (stat),
        .pop_value  (out_ch.pop_value),
        .status     (out_ch.status)
    );
endmodule

// ===== src/dssm_ram.sv =====
// Generic single-port RAM with a registered read.
module dssm_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[addr];
        end
    end

    assign rdata = rdata_reg;
endmodule

// ===== src/dssm_ctrl.sv =====
// Controller state machine that sequences requests and the result register.
module dssm_ctrl
    import dssm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  mode_t      mode,
    output logic       out_valid,
    input  logic       out_ready,
    input  dssm_stat_t stat,
    output dssm_cmd_t  cmd
);
    typedef enum logic {
        S_IDLE,
        S_READ
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;
    logic   pop_hit;

    always_comb
    begin
        out_free = !out_valid_reg || out_ready;
        case (mode)
            MODE_POP_A: pop_hit = !stat.a_empty;
            MODE_POP_B: pop_hit = !stat.b_empty;
            default:    pop_hit = 1'b0;
        endcase

        in_ready     = (state_reg == S_IDLE) && out_free;
        cmd.exec     = in_valid && in_ready;
        cmd.load_imm = cmd.exec && !pop_hit;
        cmd.load_mem = (state_reg == S_READ) && out_free;

        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd.exec && pop_hit)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                if (cmd.load_mem)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        if (cmd.load_imm || cmd.load_mem)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
endmodule

// ===== src/dssm_dp.sv =====
// Datapath with the stack counts, the shared word memory and the result register.
module dssm_dp
    import dssm_pkg::*;
#(
    parameter int unsigned DEPTH = DEPTH_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  mode_t                    mode,
    input  logic signed [WORD_W-1:0] push_value,
    input  dssm_cmd_t                cmd,
    output dssm_stat_t               stat,
    output logic signed [WORD_W-1:0] pop_value,
    output status_t                  status
);
    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [CW:0]   DEPTH_S = (CW + 1)'(DEPTH);

    logic [CW-1:0]            count_a_reg;
    logic [CW-1:0]            count_a_next;
    logic [CW-1:0]            count_b_reg;
    logic [CW-1:0]            count_b_next;
    logic [CW:0]              count_sum;
    logic                     room;
    logic [CW-1:0]            addr_full;
    logic                     ram_we;
    logic                     ram_re;
    logic [WORD_W-1:0]        ram_rdata;
    logic signed [WORD_W-1:0] imm_value;
    status_t                  imm_status;
    logic signed [WORD_W-1:0] pop_value_reg;
    status_t                  status_reg;

    always_comb
    begin
        count_sum    = {1'b0, count_a_reg} + {1'b0, count_b_reg};
        room         = count_sum < DEPTH_S;
        stat.a_empty = (count_a_reg == '0);
        stat.b_empty = (count_b_reg == '0);

        count_a_next = count_a_reg;
        count_b_next = count_b_reg;
        addr_full    = count_a_reg;
        ram_we       = 1'b0;
        ram_re       = 1'b0;
        imm_value    = PUSH_RESULT_VALUE;
        imm_status   = ST_OK;

        case (mode)
            MODE_PUSH_A:
            begin
                addr_full = count_a_reg;
                if (room)
                begin
                    ram_we       = cmd.exec;
                    count_a_next = count_a_reg + CW'(1);
                end
                else
                begin
                    imm_status = ST_OVERFLOW;
                end
            end
            MODE_PUSH_B:
            begin
                addr_full = DEPTH_C - CW'(1) - count_b_reg;
                if (room)
                begin
                    ram_we       = cmd.exec;
                    count_b_next = count_b_reg + CW'(1);
                end
                else
                begin
                    imm_status = ST_OVERFLOW;
                end
            end
            MODE_POP_A:
            begin
                addr_full = count_a_reg - CW'(1);
                if (!stat.a_empty)
                begin
                    ram_re       = cmd.exec;
                    count_a_next = count_a_reg - CW'(1);
                end
                else
                begin
                    imm_value  = POP_FAIL_VALUE;
                    imm_status = ST_UNDERFLOW;
                end
            end
            MODE_POP_B:
            begin
                addr_full = DEPTH_C - count_b_reg;
                if (!stat.b_empty)
                begin
                    ram_re       = cmd.exec;
                    count_b_next = count_b_reg - CW'(1);
                end
                else
                begin
                    imm_value  = POP_FAIL_VALUE;
                    imm_status = ST_UNDERFLOW;
                end
            end
            default:
            begin
                imm_status = ST_OK;
            end
        endcase
    end

    dssm_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (addr_full[AW-1:0]),
        .wdata (push_value),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_a_reg <= '0;
            count_b_reg <= '0;
        end
        else if (cmd.exec)
        begin
            count_a_reg <= count_a_next;
            count_b_reg <= count_b_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_imm)
        begin
            pop_value_reg <= imm_value;
            status_reg    <= imm_status;
        end
        else if (cmd.load_mem)
        begin
            pop_value_reg <= ram_rdata;
            status_reg    <= ST_OK;
        end
    end

    assign pop_value = pop_value_reg;
    assign status    = status_reg;
endmodule

// ===== src/dssm_checker.sv =====
// Port checker for the dual stack shared memory unit and its bind statement.
`include "dual_stack_shared_memory_unit_assert.svh"

module dssm_checker
    import dssm_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     out_valid,
    input logic                     out_ready,
    input logic signed [WORD_W-1:0] pop_value,
    input status_t                  status
);
    `DSSM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(pop_value) && $stable(status), "Stalled result changed.")
    `DSSM_ASSERT_SAME(a_underflow_value, clk, rst_n, out_valid && (status == ST_UNDERFLOW), pop_value == POP_FAIL_VALUE, "Underflow result is not all ones.")
    `DSSM_ASSERT_SAME(a_overflow_value, clk, rst_n, out_valid && (status == ST_OVERFLOW), pop_value == PUSH_RESULT_VALUE, "Overflow result is not zero.")
    `DSSM_ASSERT_SAME(a_status_code, clk, rst_n, out_valid, (status == ST_OK) || (status == ST_OVERFLOW) || (status == ST_UNDERFLOW), "Result status code is undefined.")
endmodule

bind dual_stack_shared_memory_unit dssm_checker u_dssm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .pop_value (out_ch.pop_value),
    .status    (out_ch.status)
);

// ===== sim/tb_dssm_scoreboard_pkg.sv =====
// Scoreboard class that predicts and checks the results of the dual stack unit.
package tb_dssm_scoreboard_pkg;
    import dssm_pkg::*;

    class stack_scoreboard;
        logic signed [WORD_W-1:0] words [DEPTH_DEF];
        int unsigned              count_a;
        int unsigned              count_b;
        logic signed [WORD_W-1:0] expected_value [$];
        status_t                  expected_status [$];
        int                       errors;

        function new();
            count_a = 0;
            count_b = 0;
            errors  = 0;
        endfunction

        function int outstanding();
            return expected_value.size();
        endfunction

        function void note_request(mode_t mode, logic signed [WORD_W-1:0] value);
            logic signed [WORD_W-1:0] result;
            status_t                  status;
            result = PUSH_RESULT_VALUE;
            status = ST_OK;
            case (mode)
                MODE_PUSH_A, MODE_PUSH_B:
                begin
                    if (count_a + count_b >= DEPTH_DEF)
                    begin
                        status = ST_OVERFLOW;
                    end
                    else if (mode == MODE_PUSH_A)
                    begin
                        words[count_a] = value;
                        count_a++;
                    end
                    else
                    begin
                        words[DEPTH_DEF - 1 - count_b] = value;
                        count_b++;
                    end
                end
                MODE_POP_A:
                begin
                    if (count_a == 0)
                    begin
                        status = ST_UNDERFLOW;
                        result = POP_FAIL_VALUE;
                    end
                    else
                    begin
                        count_a--;
                        result = words[count_a];
                    end
                end
                default:
                begin
                    if (count_b == 0)
                    begin
                        status = ST_UNDERFLOW;
                        result = POP_FAIL_VALUE;
                    end
                    else
                    begin
                        count_b--;
                        result = words[DEPTH_DEF - 1 - count_b];
                    end
                end
            endcase
            expected_value.push_back(result);
            expected_status.push_back(status);
        endfunction

        function void check_result(logic signed [WORD_W-1:0] pop_value, status_t status);
            logic signed [WORD_W-1:0] want_value;
            status_t                  want_status;
            if (expected_value.size() == 0)
            begin
                $error("result transaction arrived with no request pending");
                errors++;
                return;
            end
            want_value  = expected_value.pop_front();
            want_status = expected_status.pop_front();
            if (pop_value !== want_value)
            begin
                $error("pop_value mismatch: expected %0d, actual %0d", want_value, pop_value);
                errors++;
            end
            if (status !== want_status)
            begin
                $error("status mismatch: expected %0d, actual %0d", want_status, status);
                errors++;
            end
        endfunction
    endclass

endpackage

// ===== sim/tb_top.sv =====
// Top level testbench that drives random stack operations and checks every result.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import dssm_pkg::*;
    import tb_dssm_scoreboard_pkg::*;

    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 10;
    localparam int PHASE_ITEMS    = 490;

    logic clk = 1'b0;
    logic rst_n;

    dssm_in_if  in_ch ();
    dssm_out_if out_ch ();

    dual_stack_shared_memory_unit #(
        .DEPTH (DEPTH_DEF)
    ) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    stack_scoreboard sb = new();

    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    bit hold_request       = 1'b0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    task automatic send_item(input mode_t mode, input logic signed [WORD_W-1:0] value);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.mode       <= mode;
        in_ch.push_value <= value;
        do
            @(posedge clk);
        while (!in_ch.ready);
        sb.note_request(mode, value);
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.outstanding() > 0)
        begin
            @(posedge clk);
        end
    endtask

    function automatic mode_t pick_mode(int push_pct, int a_pct);
        bit push;
        bit to_a;
        push = $urandom_range(99) < push_pct;
        to_a = $urandom_range(99) < a_pct;
        if (push)
        begin
            return to_a ? MODE_PUSH_A : MODE_PUSH_B;
        end
        return to_a ? MODE_POP_A : MODE_POP_B;
    endfunction

    function automatic logic signed [WORD_W-1:0] pick_word();
        case ($urandom_range(15))
            0:       return '0;
            1:       return '1;
            2:       return 32'sh7fff_ffff;
            3:       return 32'sh8000_0000;
            default: return $urandom;
        endcase
    endfunction

    task automatic run_phase(input int items, input int idle_pct, input int stall_pct,
                             input bit with_hold);
        int sent;
        int burst_len;
        int push_pct;
        int a_pct;
        int k;
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        sent = 0;
        while (sent < items)
        begin
            burst_len = $urandom_range(250, 20);
            case ($urandom_range(3))
                0, 1:    push_pct = 85;
                2:       push_pct = 50;
                default: push_pct = 15;
            endcase
            case ($urandom_range(2))
                0:       a_pct = 20;
                1:       a_pct = 50;
                default: a_pct = 80;
            endcase
            for (k = 0; k < burst_len && sent < items; k++)
            begin
                if (with_hold && sent == 120)
                begin
                    hold_request = 1'b1;
                end
                send_item(pick_mode(push_pct, a_pct), pick_word());
                sent++;
            end
        end
        wait_drained();
    endtask

    initial
    begin
        int hold_left;
        hold_left = 0;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_ch.valid && out_ch.ready)
            begin
                sb.check_result(out_ch.pop_value, out_ch.status);
            end
            if (hold_request)
            begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                out_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
            end
        end
    end

    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
        end
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        in_ch.valid      <= 1'b0;
        in_ch.mode       <= MODE_PUSH_A;
        in_ch.push_value <= '0;
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty stacks first, then extreme words through both stacks in LIFO order.
        send_item(MODE_POP_A, 32'sd5);
        send_item(MODE_POP_B, 32'sd7);
        send_item(MODE_PUSH_A, 32'sh7fff_ffff);
        send_item(MODE_PUSH_A, 32'sh8000_0000);
        send_item(MODE_PUSH_B, '1);
        send_item(MODE_PUSH_B, '0);
        send_item(MODE_PUSH_A, 32'sh5555_5555);
        send_item(MODE_PUSH_B, 32'shaaaa_aaaa);
        send_item(MODE_POP_A, '1);
        send_item(MODE_POP_B, '1);
        send_item(MODE_POP_A, '0);
        send_item(MODE_POP_B, '0);
        send_item(MODE_POP_A, '0);
        send_item(MODE_POP_B, '0);
        send_item(MODE_POP_A, '0);
        send_item(MODE_POP_B, '0);
        send_item(MODE_PUSH_B, 32'sh0000_0001);
        send_item(MODE_POP_B, '0);
        wait_drained();

        run_phase(PHASE_ITEMS, 0, 0, 1'b1);
        run_phase(PHASE_ITEMS, 47, 0, 1'b0);
        run_phase(PHASE_ITEMS, 0, 47, 1'b0);
        run_phase(PHASE_ITEMS, 14, 14, 1'b0);

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.outstanding() > 0)
        begin
            $error("%0d expected results never arrived", sb.outstanding());
        end
        if (sb.errors == 0 && sb.outstanding() == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
